// ----- rtl/sftg_pkg.sv -----
// Package for the stepped frequency toggle generator.
// Holds the request and result types, the controller state, command and status types and codes.
// No dependencies.
`timescale 1ns / 1ps

package sftg_pkg;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic REG_ENTRY_COUNT   = 1'b0;
    localparam logic REG_AVERAGE_DECAY = 1'b1;

    localparam logic [9:0]  DECAY_RESET = 10'd100;
    localparam logic [9:0]  US_PER_MS   = 10'd1000;
    localparam logic [28:0] HALF_NUM    = 29'd500000000;
    localparam logic [31:0] LATE_SAT    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now_ms;
        logic [3:0]  write_index;
        logic [19:0] write_freq_mhz;
        logic [31:0] write_duration_ms;
    } item_t;

    typedef struct packed {
        logic        level;
        logic        toggled;
        logic        freq_changed;
        logic        active;
        logic [3:0]  current_index;
        logic [28:0] half_period_us;
        logic [31:0] lateness_us;
        logic [31:0] max_lateness_us;
        logic [31:0] average_lateness_us;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DECIDE,
        ST_DIV,
        ST_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic decide;
        logic start_div;
        logic finish;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic tick_go;
        logic due;
        logic div_busy;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/stepped_frequency_toggle_generator.sv -----
// Top level of the stepped frequency toggle generator: APB registers, controller, datapath.
// Depends on sftg_pkg, sftg_ctrl, sftg_dp.
//
// Usage: requests arrive on item/item_valid/item_ready, one result per request leaves on
// result/result_valid/result_ready. A request is a tick, a table write or a restart.
// Registers entry_count (0x0) and average_decay (0x4) sit on the APB port and are to be
// written by the user only while the block is idle; the block itself does not enforce this.
// Flow: a write, restart, unused op or inactive tick goes from acceptance through EVAL
// to EMIT; an active tick that does not toggle also passes DECIDE. A toggling tick goes
// on through DIV and WAIT, waiting for the 50-bit average divider, which retires two
// quotient bits per cycle, and the half-period divider. One request is handled at a time;
// the next is taken the cycle after the result is loaded into the output register.
// Reset clears pointer, level, timestamps, half period and statistics; the
// entry tables hold nothing until written.
// A stalled receiver holds the result; the block takes one more request and then
// waits for the output register to drain.
`timescale 1ns / 1ps

module stepped_frequency_toggle_generator #(
    parameter int MAX_ENTRIES = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              item_valid,
    output logic              item_ready,
    input  sftg_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output sftg_pkg::result_t result
);

    logic [4:0]        entry_count_reg;
    logic [9:0]        decay_reg;
    logic              wr_en;
    sftg_pkg::cmd_t    cmd;
    sftg_pkg::status_t status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            decay_reg       <= sftg_pkg::DECAY_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                sftg_pkg::REG_ENTRY_COUNT:   entry_count_reg <= pwdata[4:0];
                sftg_pkg::REG_AVERAGE_DECAY: decay_reg       <= pwdata[9:0];
                default:                     decay_reg       <= decay_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            sftg_pkg::REG_ENTRY_COUNT:   prdata = 32'(entry_count_reg);
            sftg_pkg::REG_AVERAGE_DECAY: prdata = 32'(decay_reg);
            default:                     prdata = '0;
        endcase
    end

    sftg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    sftg_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .entry_count   (entry_count_reg),
        .average_decay (decay_reg),
        .cmd           (cmd),
        .status        (status),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

endmodule

// ----- rtl/sftg_div.sv -----
// Iterative restoring divider, two quotient bits per cycle.
// Uses no package.
`timescale 1ns / 1ps

module sftg_div #(
    parameter int NW = 50,
    parameter int DW = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic [NW-1:0] quotient
);

    localparam int PW    = NW + (NW % 2);
    localparam int STEPS = PW / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [PW-1:0] q_reg, q_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] div_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;

    always_comb
    begin
        logic [DW:0]   r;
        logic [PW-1:0] q;
        logic [DW-1:0] rm;
        logic          ge;
        q  = q_reg;
        rm = rem_reg;
        for (int s = 0; s < 2; s++)
        begin
            r  = {rm, q[PW-1]};
            ge = (r >= {1'b0, div_reg});
            if (ge)
            begin
                r = r - {1'b0, div_reg};
            end
            rm = r[DW-1:0];
            q  = {q[PW-2:0], ge};
        end
        q_next   = q;
        rem_next = rm;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= PW'(dividend);
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg[NW-1:0];

endmodule

// ----- rtl/sftg_ctrl.sv -----
// Controller state machine for the stepped frequency toggle generator.
// Depends on sftg_pkg.
`timescale 1ns / 1ps

module sftg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  sftg_pkg::status_t status,
    output sftg_pkg::cmd_t   cmd
);

    sftg_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sftg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sftg_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = sftg_pkg::ST_EVAL;
                end
            end
            sftg_pkg::ST_EVAL:
            begin
                state_next = status.tick_go ? sftg_pkg::ST_DECIDE : sftg_pkg::ST_EMIT;
            end
            sftg_pkg::ST_DECIDE:
            begin
                state_next = status.due ? sftg_pkg::ST_DIV : sftg_pkg::ST_EMIT;
            end
            sftg_pkg::ST_DIV:
            begin
                state_next = sftg_pkg::ST_WAIT;
            end
            sftg_pkg::ST_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = sftg_pkg::ST_EMIT;
                end
            end
            sftg_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = sftg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sftg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            sftg_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.load   = item_valid;
            end
            sftg_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            sftg_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
            end
            sftg_pkg::ST_DIV:
            begin
                cmd.start_div = 1'b1;
            end
            sftg_pkg::ST_WAIT:
            begin
                cmd.finish = !status.div_busy;
            end
            sftg_pkg::ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/sftg_dp.sv -----
// Datapath: entry tables, timing state, lateness statistics and the result register.
// Depends on sftg_pkg and sftg_div.
`timescale 1ns / 1ps

module sftg_dp #(
    parameter int MAX_ENTRIES = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sftg_pkg::item_t   item,
    input  logic [4:0]        entry_count,
    input  logic [9:0]        average_decay,
    input  sftg_pkg::cmd_t    cmd,
    output sftg_pkg::status_t status,
    output logic              result_valid,
    input  logic              result_ready,
    output sftg_pkg::result_t result
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int TB = TIME_BITS;

    logic [19:0] freq_tab [MAX_ENTRIES];
    logic [31:0] dur_tab  [MAX_ENTRIES];

    sftg_pkg::item_t   req_reg;
    sftg_pkg::result_t out_reg;
    logic              out_valid_reg;

    logic [IW-1:0] ptr_reg;
    logic          level_reg;
    logic [TB-1:0] last_reg;
    logic [TB-1:0] start_reg;
    logic [28:0]   half_reg;
    logic [31:0]   max_reg;
    logic [39:0]   avg_reg;

    logic          toggled_reg;
    logic          changed_reg;
    logic [31:0]   late_reg;
    logic          big_reg;
    logic [41:0]   us_reg;
    logic          adv_reg;
    logic [49:0]   prod_reg;
    logic          fzero_reg;

    logic [63:0]   now_w;
    logic [TB-1:0] now_t;
    logic [TB-1:0] elapsed;
    logic [63:0]   elapsed_w;
    logic [TB-1:0] since_start;
    logic [63:0]   since_w;
    logic [31:0]   used;
    logic          active;
    logic [31:0]   widx_w;
    logic [9:0]    d_eff;
    logic          due;
    logic [41:0]   late_diff;
    logic [31:0]   late_val;
    logic [31:0]   ptr_w;
    logic [IW-1:0] ptr_inc;
    logic [49:0]   avg_dividend;
    logic [49:0]   avg_q;
    logic [28:0]   half_q;
    logic          avg_busy;
    logic          half_busy;

    assign now_w       = {32'd0, req_reg.now_ms};
    assign now_t       = now_w[TB-1:0];
    assign elapsed     = now_t - last_reg;
    assign elapsed_w   = 64'(elapsed);
    assign since_start = now_t - start_reg;
    assign since_w     = 64'(since_start);
    assign used        = (32'(entry_count) < 32'(MAX_ENTRIES)) ? 32'(entry_count)
                                                               : 32'(MAX_ENTRIES);
    assign ptr_w       = 32'(ptr_reg);
    assign active      = (used != 32'd0) && (ptr_w < used);
    assign widx_w      = 32'(req_reg.write_index);
    assign d_eff       = (average_decay == 10'd0) ? 10'd1 : average_decay;
    assign ptr_inc     = ((ptr_w + 32'd1) == used) ? '0 : IW'(ptr_w + 32'd1);

    assign due       = big_reg || (us_reg >= 42'(half_reg));
    assign late_diff = us_reg - 42'(half_reg);
    assign late_val  = big_reg ? sftg_pkg::LATE_SAT
                     : ((late_diff[41:32] != 10'd0) ? sftg_pkg::LATE_SAT : late_diff[31:0]);

    assign avg_dividend = prod_reg + 50'({late_reg, 8'd0});

    sftg_div #(.NW(50), .DW(10)) u_avg_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (avg_dividend),
        .divisor  (d_eff),
        .busy     (avg_busy),
        .quotient (avg_q)
    );

    sftg_div #(.NW(29), .DW(20)) u_half_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (sftg_pkg::HALF_NUM),
        .divisor  (freq_tab[ptr_reg]),
        .busy     (half_busy),
        .quotient (half_q)
    );

    assign status.tick_go  = (req_reg.op == sftg_pkg::OP_TICK) && active;
    assign status.due      = due;
    assign status.div_busy = avg_busy || half_busy;
    assign status.out_free = !out_valid_reg || result_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= item;
        end
        if (cmd.eval && (req_reg.op == sftg_pkg::OP_WRITE)
            && (widx_w < 32'(MAX_ENTRIES)))
        begin
            freq_tab[widx_w[IW-1:0]] <= req_reg.write_freq_mhz;
            dur_tab[widx_w[IW-1:0]]  <= req_reg.write_duration_ms;
        end
        if (cmd.eval)
        begin
            big_reg  <= (elapsed_w[63:32] != 32'd0);
            us_reg   <= 42'(elapsed_w[31:0]) * 42'(sftg_pkg::US_PER_MS);
            adv_reg  <= (since_w >= 64'(dur_tab[ptr_reg]));
            prod_reg <= 50'(avg_reg) * 50'(d_eff - 10'd1);
        end
        if (cmd.start_div)
        begin
            fzero_reg <= (freq_tab[ptr_reg] == 20'd0);
        end
        if (cmd.emit)
        begin
            out_reg.level               <= level_reg;
            out_reg.toggled             <= toggled_reg;
            out_reg.freq_changed        <= changed_reg;
            out_reg.active              <= active;
            out_reg.current_index       <= 4'(ptr_w);
            out_reg.half_period_us      <= half_reg;
            out_reg.lateness_us         <= late_reg;
            out_reg.max_lateness_us     <= max_reg;
            out_reg.average_lateness_us <= avg_reg[39:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ptr_reg       <= '0;
            level_reg     <= 1'b0;
            last_reg      <= '0;
            start_reg     <= '0;
            half_reg      <= '0;
            max_reg       <= '0;
            avg_reg       <= '0;
            toggled_reg   <= 1'b0;
            changed_reg   <= 1'b0;
            late_reg      <= '0;
        end
        else
        begin
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                toggled_reg <= 1'b0;
                changed_reg <= 1'b0;
                late_reg    <= '0;
            end
            if (cmd.eval && (req_reg.op == sftg_pkg::OP_RESTART))
            begin
                ptr_reg  <= '0;
                half_reg <= '0;
            end
            if (cmd.decide && due)
            begin
                late_reg    <= late_val;
                toggled_reg <= 1'b1;
                level_reg   <= !level_reg;
                last_reg    <= now_t;
                if (late_val > max_reg)
                begin
                    max_reg <= late_val;
                end
                if (adv_reg)
                begin
                    ptr_reg     <= ptr_inc;
                    start_reg   <= now_t;
                    changed_reg <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                avg_reg  <= avg_q[39:0];
                half_reg <= fzero_reg ? sftg_pkg::HALF_NUM : half_q;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- rtl/sftg_checker.sv -----
// Port-level checks for the stepped frequency toggle generator, bound to the top level.
// Depends on sftg_pkg and stepped_frequency_toggle_generator.
`timescale 1ns / 1ps

module sftg_port_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input sftg_pkg::result_t result
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result dropped or changed while stalled");

    a_change_needs_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.freq_changed |-> result.toggled)
        else $error("entry advanced without a toggle");

    a_quiet_late: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.toggled |-> result.lateness_us == 32'd0)
        else $error("lateness reported without a toggle");

    a_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.toggled |-> result.max_lateness_us >= result.lateness_us)
        else $error("maximum below current lateness");

    a_toggle_active: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.toggled |-> result.active)
        else $error("toggle while inactive");

endmodule

bind stepped_frequency_toggle_generator sftg_port_checker u_sftg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
